FILE: design/rbb_pkg.sv
// ----------------------------------------------------------------------------
// rbb_pkg: shared types and constants for the Renko brick builder
// Holds the tick and brick beat formats, the register indexes, the trend
// codes and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package rbb_pkg;

  // Most bricks one tick may produce before the run is cut short.
  localparam int MAX_BRICKS = 16;
  localparam int CNT_W      = $clog2(MAX_BRICKS + 1);

  localparam int PRICE_W  = 32;
  localparam int TIME_W   = 63;
  localparam int HEIGHT_W = 24;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

  // Trend codes; the unused code behaves as neutral.
  localparam logic [1:0] TREND_NEUTRAL = 2'd0;
  localparam logic [1:0] TREND_UP      = 2'd1;
  localparam logic [1:0] TREND_DOWN    = 2'd2;

  typedef struct packed {
    logic [PRICE_W-1:0] tick_price;
    logic [TIME_W-1:0]  tick_time;
  } tick_t;

  typedef struct packed {
    logic [PRICE_W-1:0] brick_open;
    logic [PRICE_W-1:0] brick_close;
    logic               brick_up;
    logic [TIME_W-1:0]  brick_time;
    logic               last_of_tick;
    logic               truncated;
  } brick_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;  // latch the incoming tick and clear the brick count
    logic take;   // hold the brick that forms now and step the level
    logic emit;   // move the held brick into the output register
    logic last;   // the emitted brick ends the tick
    logic trunc;  // the emitted brick was cut short by the limit
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic forms;      // a further brick forms at the tick price
    logic at_limit;   // the tick has already produced MAX_BRICKS bricks
    logic slot_free;  // the output register can take a beat this cycle
  } dp_sts_t;

endpackage

FILE: design/renko_brick_builder_core.sv
// ----------------------------------------------------------------------------
// renko_brick_builder_core: Renko chart brick builder
// Turns price ticks into Renko bricks, continuing the trend on a one-brick
// move and reversing it on a two-brick move, with a per-tick brick limit.
//
//   channel  direction  handshake          payload
//   in       sink       in_valid/in_ready    tick_t  (tick_price, tick_time)
//   out      source     out_valid/out_ready  brick_t (open, close, up, time,
//                                                    last_of_tick, truncated)
//   cfg      sink       cfg_we               cfg_index, cfg_data
//
// One tick is handled at a time: the accept state, a state that evaluates the
// first brick, then one brick per cycle while the sink does not stall, and a
// tick making none goes back to accept after the evaluation. The single brick
// compare and add stage in the datapath sets that pace. Reset loads level 0,
// neutral trend and brick height 1. A stalled sink holds the brick sequence;
// the next tick is taken once the last brick of the current one is released.
// ----------------------------------------------------------------------------
module renko_brick_builder_core import rbb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tick_t                in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output brick_t               out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer.
  rbb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Brick arithmetic and storage.
  rbb_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: design/rbb_ctrl.sv
// ----------------------------------------------------------------------------
// rbb_ctrl: sequencer for the Renko brick builder
// Accepts one tick at a time, lets the datapath form bricks one by one, and
// releases each held brick once it is known whether another one follows.
// ----------------------------------------------------------------------------
module rbb_ctrl import rbb_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_FIRST = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t state, state_next;
  logic   more;

  assign in_ready = (state == ST_IDLE);
  // Another brick joins this tick only while the limit has not been reached.
  assign more     = sts.forms && !sts.at_limit;

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = ST_FIRST;
        end
      end
      ST_FIRST: begin
        if (sts.forms) begin
          cmd.take   = 1'b1;
          state_next = ST_DRAIN;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DRAIN: begin
        if (sts.slot_free) begin
          cmd.emit  = 1'b1;
          cmd.last  = !more;
          cmd.trunc = sts.forms && sts.at_limit;
          if (more) begin
            cmd.take = 1'b1;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A beat is only released into a free output register.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.slot_free) else $error("brick released into a busy output");

  // No brick is taken past the per-tick limit.
  a_take_limit: assert property (@(posedge clk) disable iff (rst)
    cmd.take |-> !sts.at_limit) else $error("brick taken beyond the limit");

  // An accepted tick is always evaluated in the following cycle.
  a_start_first: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> state == ST_FIRST) else $error("tick not evaluated after accept");

endmodule

FILE: design/rbb_dp.sv
// ----------------------------------------------------------------------------
// rbb_dp: datapath of the Renko brick builder
// Holds the registers, the level and trend, the current tick, one formed
// brick waiting for its flags, and the output register.
// ----------------------------------------------------------------------------
module rbb_dp import rbb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  tick_t                in_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  dp_cmd_t              cmd,
  output dp_sts_t              sts,
  output logic                 out_valid,
  input  logic                 out_ready,
  output brick_t               out_data
);

  localparam int EXT_W = PRICE_W + 2;

  logic [HEIGHT_W-1:0] height;
  logic [PRICE_W-1:0]  level;
  logic [1:0]          trend;
  logic [PRICE_W-1:0]  price;
  logic [TIME_W-1:0]   tick_time;
  logic [CNT_W-1:0]    count;

  // Held brick, waiting to learn whether it ends the tick.
  logic [PRICE_W-1:0]  hold_open;
  logic [PRICE_W-1:0]  hold_close;
  logic                hold_up;

  // Brick that forms now from the current level and trend.
  logic [EXT_W-1:0]    h1, h2, l, p, l_plus1, l_plus2, l_minus1, l_minus2;
  logic                rise1, rise2, fall1, fall2;
  logic                forms;
  logic [PRICE_W-1:0]  nb_open, nb_close;
  logic                nb_up;
  logic [1:0]          nb_trend;

  // Brick arithmetic, done wide so nothing wraps near either end.
  always_comb begin
    h1       = (height == '0) ? EXT_W'(1) : EXT_W'(height);
    h2       = h1 << 1;
    l        = EXT_W'(level);
    p        = EXT_W'(price);
    l_plus1  = l + h1;
    l_plus2  = l + h2;
    l_minus1 = l - h1;
    l_minus2 = l - h2;
    rise1    = (p >= l_plus1);
    rise2    = (p >= l_plus2);
    fall1    = (l >= h1) && (p <= l_minus1);
    fall2    = (l >= h2) && (p <= l_minus2);
  end

  // Pick the brick for the present trend.
  always_comb begin
    forms    = 1'b0;
    nb_open  = level;
    nb_close = l_plus1[PRICE_W-1:0];
    nb_up    = 1'b1;
    nb_trend = TREND_UP;
    unique case (trend)
      TREND_UP: begin
        if (rise1) begin
          forms = 1'b1;
        end else if (fall2) begin
          forms    = 1'b1;
          nb_open  = l_minus1[PRICE_W-1:0];
          nb_close = l_minus2[PRICE_W-1:0];
          nb_up    = 1'b0;
          nb_trend = TREND_DOWN;
        end
      end
      TREND_DOWN: begin
        if (fall1) begin
          forms    = 1'b1;
          nb_close = l_minus1[PRICE_W-1:0];
          nb_up    = 1'b0;
          nb_trend = TREND_DOWN;
        end else if (rise2) begin
          forms    = 1'b1;
          nb_open  = l_plus1[PRICE_W-1:0];
          nb_close = l_plus2[PRICE_W-1:0];
        end
      end
      default: begin
        if (rise1) begin
          forms = 1'b1;
        end else if (fall1) begin
          forms    = 1'b1;
          nb_close = l_minus1[PRICE_W-1:0];
          nb_up    = 1'b0;
          nb_trend = TREND_DOWN;
        end
      end
    endcase
  end

  assign sts.forms     = forms;
  assign sts.at_limit  = (count == CNT_W'(MAX_BRICKS));
  assign sts.slot_free = !out_valid || out_ready;

  // Configuration, level, trend and brick count.
  always_ff @(posedge clk) begin
    if (rst) begin
      height <= HEIGHT_W'(1);
      level  <= '0;
      trend  <= TREND_NEUTRAL;
      count  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ANCHOR: begin
            level <= cfg_data[PRICE_W-1:0];
            trend <= TREND_NEUTRAL;
          end
          CFG_HEIGHT: height <= cfg_data[HEIGHT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.start) begin
        count <= '0;
      end else if (cmd.take) begin
        level <= nb_close;
        trend <= nb_trend;
        count <= count + CNT_W'(1);
      end
    end
  end

  // Tick payload and the held brick.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      price     <= in_data.tick_price;
      tick_time <= in_data.tick_time;
    end
    if (cmd.take) begin
      hold_open  <= nb_open;
      hold_close <= nb_close;
      hold_up    <= nb_up;
    end
  end

  // Output register: one beat waits here while the sink stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.brick_open   <= hold_open;
      out_data.brick_close  <= hold_close;
      out_data.brick_up     <= hold_up;
      out_data.brick_time   <= tick_time;
      out_data.last_of_tick <= cmd.last;
      out_data.truncated    <= cmd.trunc;
    end
  end

  // A released brick is presented in the next cycle.
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid) else $error("released brick not presented");

  // The brick count never runs past the limit.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_BRICKS)) else $error("brick count out of range");

  // A truncated brick always ends its tick.
  a_trunc_last: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && cmd.trunc |-> cmd.last) else $error("truncated brick not last");

endmodule

FILE: sim/renko_brick_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// renko_brick_checker: brick prediction and comparison for the brick builder
// Watches the tick, brick and register channels of the core. It keeps its own
// level, trend and brick height, works out the bricks that every accepted
// tick must produce, and compares each accepted brick beat, field by field,
// with the oldest brick still owed.
// ----------------------------------------------------------------------------
module renko_brick_checker import rbb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  tick_t                in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  brick_t               out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   mismatches,
  output int                   pending,
  output int                   bricks_seen,
  output int                   reversals,
  output int                   cut_runs
);

  // One brick step as decided from the level and trend.
  typedef struct packed {
    logic [PRICE_W-1:0] open_lvl;
    logic [PRICE_W-1:0] close_lvl;
    logic               rising;
    logic [1:0]         trend_after;
  } brick_step_t;

  logic [PRICE_W-1:0]  level;
  logic [1:0]          trend;
  logic [HEIGHT_W-1:0] height;
  brick_t              owed_bricks[$];
  brick_t              want_brick;

  // Decides whether one more brick forms at this price. Sums are taken at
  // 64 bits so that nothing wraps near either end of the price range.
  function automatic logic brick_forms(input logic [PRICE_W-1:0] price,
                                       input logic [PRICE_W-1:0] lvl,
                                       input logic [1:0] tr,
                                       input logic [63:0] h,
                                       output brick_step_t s);
    logic [63:0] p;
    logic [63:0] l;
    logic        up_one;
    logic        dn_one;
    logic        up_two;
    logic        dn_two;
    p = 64'(price);
    l = 64'(lvl);
    up_one = p >= l + h;
    dn_one = (l >= h) && (p <= l - h);
    up_two = p >= l + 2 * h;
    dn_two = (l >= 2 * h) && (p <= l - 2 * h);
    brick_forms = 1'b1;
    case (tr)
      TREND_UP: begin
        if (up_one) begin
          s = '{lvl, 32'(l + h), 1'b1, TREND_UP};
        end else if (dn_two) begin
          s = '{32'(l - h), 32'(l - 2 * h), 1'b0, TREND_DOWN};
        end else begin
          brick_forms = 1'b0;
        end
      end
      TREND_DOWN: begin
        if (dn_one) begin
          s = '{lvl, 32'(l - h), 1'b0, TREND_DOWN};
        end else if (up_two) begin
          s = '{32'(l + h), 32'(l + 2 * h), 1'b1, TREND_UP};
        end else begin
          brick_forms = 1'b0;
        end
      end
      // Neutral, and the unused code that behaves as neutral.
      default: begin
        if (up_one) begin
          s = '{lvl, 32'(l + h), 1'b1, TREND_UP};
        end else if (dn_one) begin
          s = '{lvl, 32'(l - h), 1'b0, TREND_DOWN};
        end else begin
          brick_forms = 1'b0;
        end
      end
    endcase
  endfunction

  // Adds one brick at the tail of the owed list.
  function automatic void owe_brick(input brick_t b);
    owed_bricks = {owed_bricks, b};
  endfunction

  // Appends the bricks that one tick produces, marking the final one and
  // whether the per-tick limit cut the run short.
  task automatic predict_tick(input tick_t t);
    logic [63:0] h;
    brick_step_t s;
    brick_t      held;
    logic        have_held;
    int          n;
    h = (height == '0) ? 64'd1 : 64'(height);
    have_held = 1'b0;
    n = 0;
    while (n < MAX_BRICKS && brick_forms(t.tick_price, level, trend, h, s)) begin
      if (have_held) begin
        owe_brick(held);
      end
      if ((trend == TREND_UP && !s.rising) || (trend == TREND_DOWN && s.rising)) begin
        reversals++;
      end
      held.brick_open   = s.open_lvl;
      held.brick_close  = s.close_lvl;
      held.brick_up     = s.rising;
      held.brick_time   = t.tick_time;
      held.last_of_tick = 1'b0;
      held.truncated    = 1'b0;
      level = s.close_lvl;
      trend = s.trend_after;
      have_held = 1'b1;
      n++;
    end
    if (have_held) begin
      held.last_of_tick = 1'b1;
      held.truncated = (n >= MAX_BRICKS) && brick_forms(t.tick_price, level, trend, h, s);
      owe_brick(held);
    end
  endtask

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $display("%0t ns: brick %0d field %s expected 0x%0h, got 0x%0h",
               $time, bricks_seen, name, want, got);
      mismatches++;
    end
  endfunction

  // Bricks leaving are checked first, then register writes, then new ticks.
  always @(posedge clk) begin
    if (rst) begin
      level = '0;
      trend = TREND_NEUTRAL;
      height = 24'd1;
      owed_bricks.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (owed_bricks.size() == 0) begin
          $display("%0t ns: brick beat with none expected, open 0x%0h close 0x%0h",
                   $time, out_data.brick_open, out_data.brick_close);
          mismatches++;
        end else begin
          want_brick = owed_bricks.pop_front();
          check_field("brick_open", 64'(want_brick.brick_open), 64'(out_data.brick_open));
          check_field("brick_close", 64'(want_brick.brick_close), 64'(out_data.brick_close));
          check_field("brick_up", 64'(want_brick.brick_up), 64'(out_data.brick_up));
          check_field("brick_time", 64'(want_brick.brick_time), 64'(out_data.brick_time));
          check_field("last_of_tick", 64'(want_brick.last_of_tick),
                      64'(out_data.last_of_tick));
          check_field("truncated", 64'(want_brick.truncated), 64'(out_data.truncated));
        end
        bricks_seen++;
        if (out_data.truncated === 1'b1) begin
          cut_runs++;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_ANCHOR: begin
            level = cfg_data[PRICE_W-1:0];
            trend = TREND_NEUTRAL;
          end
          CFG_HEIGHT: begin
            height = cfg_data[HEIGHT_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (in_valid && in_ready) begin
        predict_tick(in_data);
      end
    end
    pending = owed_bricks.size();
  end

endmodule

FILE: sim/tb_renko_brick_builder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_renko_brick_builder_core: stimulus and verdict for the brick builder
// Drives price ticks through a valid/ready channel under several anchor and
// brick height settings: a directed set around both ends of the price range
// and the zero height, then random walks with jumps and noise. The brick
// side stalls at random and once holds off long enough to back up the core.
// ----------------------------------------------------------------------------
module tb_renko_brick_builder_core;
  import rbb_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int HOLD_CYCLES  = 120;
  localparam int SETTLE       = 6;
  localparam int LIMIT_CYCLES = 400000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid;
  logic                 in_ready;
  tick_t                in_data;
  logic                 out_valid;
  logic                 out_ready;
  brick_t               out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  int mismatches;
  int pending;
  int bricks_seen;
  int reversals;
  int cut_runs;
  int ticks_sent;
  int holds_asked;
  int holds_served;
  bit src_idle;
  bit sink_stalls;

  // Random walk state: last price offered and the effective brick height.
  logic [PRICE_W-1:0] walk_price;
  logic [63:0]        walk_h;

  renko_brick_builder_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  renko_brick_checker brick_chk (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .pending     (pending),
    .bricks_seen (bricks_seen),
    .reversals   (reversals),
    .cut_runs    (cut_runs)
  );

  always #HALF_PERIOD clk = ~clk;

  // Hard stop in case the core hangs.
  initial begin
    #(LIMIT_CYCLES * 2 * HALF_PERIOD);
    $display("tb_renko_brick_builder_core: errors");
    $finish;
  end

  // Brick side: a random stall before each beat, or one long hold on request.
  initial begin : brick_sink
    int wait_cycles;
    out_ready = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if (holds_served != holds_asked) begin
        wait_cycles = HOLD_CYCLES;
        holds_served++;
      end else begin
        wait_cycles = sink_stalls ? $urandom_range(0, 6) : 0;
      end
      if (wait_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Offers one tick and returns at the falling edge after its beat. Valid
  // stays high so that a back-to-back tick can follow without a gap.
  task automatic send_tick(input logic [PRICE_W-1:0] price, input logic [TIME_W-1:0] stamp);
    int gap;
    gap = src_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data.tick_price <= price;
    in_data.tick_time <= stamp;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    walk_price = price;
    ticks_sent++;
  endtask

  // Stops offering ticks and waits until every owed brick has left, then lets
  // a tick that made no brick settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Writes the brick height and then the anchor, which also clears the trend.
  task automatic set_regs(input logic [CFG_W-1:0] anchor, input logic [CFG_W-1:0] height_word);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= CFG_HEIGHT;
    cfg_data <= height_word;
    @(negedge clk);
    cfg_index <= CFG_ANCHOR;
    cfg_data <= anchor;
    @(negedge clk);
    cfg_we <= 1'b0;
    walk_h = (height_word[HEIGHT_W-1:0] == '0) ? 64'd1 : 64'(height_word[HEIGHT_W-1:0]);
    walk_price = anchor;
  endtask

  // Mostly moves of under four bricks around the last price, some long
  // jumps that can hit the per-tick limit, and some prices anywhere.
  task automatic random_tick();
    logic [63:0] stride;
    logic [63:0] raised;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      walk_price = $urandom;
    end else begin
      stride = (pick < 88 ? $urandom_range(0, 3) : $urandom_range(4, 24)) * walk_h
               + ($urandom % walk_h);
      if ($urandom_range(0, 1) == 1) begin
        raised = 64'(walk_price) + stride;
        walk_price = (raised > 64'hFFFF_FFFF) ? '1 : raised[PRICE_W-1:0];
      end else begin
        walk_price = (stride > 64'(walk_price)) ? '0 : walk_price - stride[PRICE_W-1:0];
      end
    end
    send_tick(walk_price, TIME_W'({$urandom, $urandom}));
  endtask

  initial begin
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_ANCHOR;
    cfg_data = '0;
    src_idle = 1'b0;
    sink_stalls = 1'b0;
    walk_price = '0;
    walk_h = 64'd1;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings, level zero, height one, no idling on either side.
    send_tick(32'd0, '0);               // nothing forms below zero
    send_tick(32'd1, '1);               // first brick sets the up trend
    send_tick(32'd0, TIME_W'(5));       // one brick against the trend is not enough
    send_tick(32'd3, TIME_W'(6));       // two bricks in a row
    send_tick(32'd1, TIME_W'(7));       // reversal down
    send_tick(32'd0, TIME_W'(8));       // down to zero
    send_tick(32'hFFFF_FFFF, TIME_W'(9));  // reversal up, cut short by the limit
    send_tick(32'hFFFF_FFFF, TIME_W'(10)); // resumes from the kept level

    // A zero height acts as one; the upper data bits are not part of it.
    set_regs(32'd100, 32'hAB00_0000);
    src_idle = 1'b1;
    sink_stalls = 1'b1;
    send_tick(32'd102, TIME_W'({$urandom, $urandom}));
    send_tick(32'd99, TIME_W'({$urandom, $urandom}));
    send_tick(32'd116, TIME_W'({$urandom, $urandom}));
    repeat (22) random_tick();

    // Level near the top of the range, then a long hold on the brick side
    // while full-range swings keep the core busy.
    set_regs(32'hFFFF_FFF0, 32'd5);
    src_idle = 1'b0;
    sink_stalls = 1'b0;
    send_tick(32'hFFFF_FFFF, TIME_W'({$urandom, $urandom}));
    send_tick(32'hFFFF_FFFF, TIME_W'({$urandom, $urandom}));
    holds_asked++;
    for (int i = 0; i < 6; i++) begin
      send_tick((i % 2 == 0) ? 32'd0 : 32'hFFFF_FFFF, TIME_W'({$urandom, $urandom}));
    end
    src_idle = 1'b1;
    repeat (20) random_tick();

    // Top anchor with the largest height.
    set_regs(32'hFFFF_FFFF, 32'h00FF_FFFF);
    sink_stalls = 1'b1;
    send_tick(32'hFFFF_FFFF, TIME_W'({$urandom, $urandom}));
    send_tick(32'd0, TIME_W'({$urandom, $urandom}));
    repeat (20) random_tick();

    // Zero anchor, medium height; idling switches on and off in stretches.
    set_regs(32'd0, 32'd1000);
    while (ticks_sent < 110) begin
      if (ticks_sent % 16 == 0) begin
        src_idle = ~src_idle;
        sink_stalls = ($urandom_range(0, 1) == 1);
      end
      random_tick();
    end

    drain();
    $display("Run covered %0d ticks and %0d bricks, %0d reversals, %0d cut short by the limit.",
             ticks_sent, bricks_seen, reversals, cut_runs);
    $display("Anchors from 0 to 0xFFFFFFFF and heights from 0 (as 1) to 0xFFFFFF were used.");
    if (mismatches == 0) begin
      $display("tb_renko_brick_builder_core: clean");
    end else begin
      $display("tb_renko_brick_builder_core: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/rbb_pkg.sv
design/rbb_ctrl.sv
design/rbb_dp.sv
design/renko_brick_builder_core.sv
sim/renko_brick_checker.sv
sim/tb_renko_brick_builder_core.sv
